// ===== rtl/voice_param_dedup_table_macros.svh =====
// assertion macros shared by the voice parameter dedup table rtl
// expects clk and arst_n in the scope of each use
`ifndef VOICE_PARAM_DEDUP_TABLE_MACROS_SVH
`define VOICE_PARAM_DEDUP_TABLE_MACROS_SVH

// same-cycle implication
`define VPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/vpd_pkg.sv =====
// types and constants for the voice parameter dedup table
// no dependencies
package vpd_pkg;

	localparam int unsigned OPS_PER_ENTRY = 4;
	localparam int unsigned OPS_TWO_MODE  = 2;
	localparam int unsigned OP_W          = 29;
	localparam int unsigned FB_W          = 3;
	localparam int unsigned ID_W          = 6;

	localparam logic [OPS_PER_ENTRY-1:0] USE_FOUR_OPS = 4'b1111;
	localparam logic [OPS_PER_ENTRY-1:0] USE_TWO_OPS  = 4'b0011;

	// one stored voice
	typedef struct packed {
		logic                              four_op;
		logic [FB_W-1:0]                   fb;
		logic [OPS_PER_ENTRY-1:0][OP_W-1:0] ops;
	} vpd_entry_t;

	// classified item handed from front to back
	typedef struct packed {
		vpd_entry_t                ent;
		logic [OPS_PER_ENTRY-1:0] use_mask;
	} vpd_item_t;

	function automatic logic vpd_match(input vpd_entry_t stored, input vpd_item_t item);
		logic hit;
		hit = (stored.four_op == item.ent.four_op) && (stored.fb == item.ent.fb);
		for (int k = 0; k < OPS_PER_ENTRY; k++) begin
			if (item.use_mask[k] && (stored.ops[k] != item.ent.ops[k])) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

// ===== rtl/vpd_if.sv =====
// channel interfaces for the voice parameter dedup table
// depends on vpd_pkg
interface vpd_in_if import vpd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                four_op_mode;
	logic [FB_W-1:0]     feedback;
	logic [OP_W-1:0]     operator_zero_fields;
	logic [OP_W-1:0]     operator_one_fields;
	logic [OP_W-1:0]     operator_two_fields;
	logic [OP_W-1:0]     operator_three_fields;

	modport source (
		output valid, four_op_mode, feedback, operator_zero_fields, operator_one_fields,
			operator_two_fields, operator_three_fields,
		input  ready
	);
	modport sink (
		input  valid, four_op_mode, feedback, operator_zero_fields, operator_one_fields,
			operator_two_fields, operator_three_fields,
		output ready
	);
endinterface

interface vpd_out_if import vpd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] voice_id;
	logic            was_found;
	logic            table_full;

	modport source (output valid, voice_id, was_found, table_full, input ready);
	modport sink (input valid, voice_id, was_found, table_full, output ready);
endinterface

// ===== rtl/vpd_front.sv =====
// front end: accepts voice beats, classifies operator use, queues them
// depends on vpd_pkg and vpd_in_if
module vpd_front import vpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	vpd_in_if.sink    voice,
	output logic      q_valid,
	input  logic      q_ready,
	output vpd_item_t q_item
);

	vpd_item_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	vpd_item_t  new_item;

	assign voice.ready = (fill_q != 2'd2);
	assign push        = voice.valid && voice.ready;
	assign q_valid     = (fill_q != 2'd0);
	assign pop         = q_valid && q_ready;
	assign q_item      = fifo_q[rd_ptr_q];

	always_comb begin
		new_item.ent.four_op = voice.four_op_mode;
		new_item.ent.fb      = voice.feedback;
		new_item.ent.ops[0]  = voice.operator_zero_fields;
		new_item.ent.ops[1]  = voice.operator_one_fields;
		new_item.ent.ops[2]  = voice.operator_two_fields;
		new_item.ent.ops[3]  = voice.operator_three_fields;
		new_item.use_mask    = voice.four_op_mode ? USE_FOUR_OPS : USE_TWO_OPS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

// ===== rtl/vpd_back.sv =====
// back end: sequential table search, append, result register
// depends on vpd_pkg, vpd_out_if and the assertion macro header
`include "voice_param_dedup_table_macros.svh"

module vpd_back import vpd_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  vpd_item_t q_item,
	vpd_out_if.source result
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t           state_q;
	vpd_item_t        item_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] addr_q;
	vpd_entry_t       mem_q [TABLE_DEPTH];
	vpd_entry_t       rdata_s1;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] res_idx_q;
	logic             res_found_q;
	logic             res_full_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_found_q;
	logic             out_full_q;

	logic             hit;
	logic             miss;
	logic             rd_en;
	logic             mem_we;
	logic             out_load;
	logic [IDX_W+ID_W-1:0] id_ext;

	assign q_ready  = (state_q == ST_IDLE);
	assign hit      = (state_q == ST_SEARCH) && rd_vld_s1 && vpd_match(rdata_s1, item_q);
	assign miss     = (state_q == ST_SEARCH) && !rd_vld_s1 && (addr_q == cnt_q);
	assign rd_en    = (state_q == ST_SEARCH) && !hit && !miss && (addr_q != cnt_q);
	assign mem_we   = miss && (cnt_q != DEPTH_C);
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || result.ready);
	assign id_ext   = {{ID_W{1'b0}}, res_idx_q};

	assign result.valid      = out_valid_q;
	assign result.voice_id   = out_id_q;
	assign result.was_found  = out_found_q;
	assign result.table_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			if (mem_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (q_valid) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit || miss) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			item_q <= q_item;
		end
		if (hit) begin
			res_idx_q   <= idx_s1;
			res_found_q <= 1'b1;
			res_full_q  <= 1'b0;
		end else if (miss) begin
			res_idx_q   <= mem_we ? cnt_q[IDX_W-1:0] : '0;
			res_found_q <= 1'b0;
			res_full_q  <= !mem_we;
		end
		if (out_load) begin
			out_id_q    <= id_ext[ID_W-1:0];
			out_found_q <= res_found_q;
			out_full_q  <= res_full_q;
		end
	end

	// table storage, one row per voice
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[cnt_q[IDX_W-1:0]] <= item_q.ent;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[addr_q[IDX_W-1:0]];
			idx_s1   <= addr_q[IDX_W-1:0];
		end
	end

	`VPD_ASSERT_NOW(a_write_room, mem_we, cnt_q < DEPTH_C, "append into full table")
	`VPD_ASSERT_NEXT(a_count_step, mem_we, cnt_q == $past(cnt_q) + 1'b1, "count did not step")
	`VPD_ASSERT_NOW(a_hit_below_count, hit, CNT_W'(idx_s1) < cnt_q, "hit past count")
	`VPD_ASSERT_NOW(a_load_after_finish, $rose(out_valid_q), $past(state_q == ST_FINISH), "stray beat")

endmodule

// ===== rtl/voice_param_dedup_table.sv =====
// top level of the voice parameter dedup table
// depends on vpd_pkg, vpd_if, vpd_front and vpd_back
//
// One voice beat in, one result beat out. The front queues up to two voices
// while the back searches the table row by row through its single memory
// read port, one stored voice per cycle in insertion order, then appends on
// a miss while the table has room. The result waits in an output register
// so the next voice can start meanwhile. The table is empty after reset and
// needs no clearing.
module voice_param_dedup_table import vpd_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	vpd_in_if.sink voice,
	vpd_out_if.source result
);

	logic      q_valid;
	logic      q_ready;
	vpd_item_t q_item;

	vpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.voice   (voice),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	vpd_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.result  (result)
	);

endmodule

// ===== tb/tb_top.sv =====
// testbench for the voice parameter dedup table: drives voice beats, predicts each result
// from a table model kept here, and checks result beats in order
// depends on vpd_pkg, vpd_if and voice_param_dedup_table
`timescale 1ns / 1ps

module tb_top;
	import vpd_pkg::*;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam logic [OP_W-1:0] OP_ONES = {OP_W{1'b1}};

	typedef struct packed {
		logic [ID_W-1:0] voice_id;
		logic            was_found;
		logic            table_full;
	} voice_result_t;

	logic clk = 1'b0;
	logic arst_n;

	vpd_in_if  voice_ch ();
	vpd_out_if result_ch ();

	voice_param_dedup_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.voice  (voice_ch),
		.result (result_ch)
	);

	vpd_entry_t    voice_table [TABLE_DEPTH];
	int unsigned   stored_voice_count = 0;
	voice_result_t expected_results [$];
	int unsigned   mismatch_count = 0;
	int unsigned   voice_gap_max = 0;
	int unsigned   result_stall_max = 0;
	int unsigned   result_hold_request = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic voices_equal(input vpd_entry_t stored, input vpd_entry_t v);
		logic same;
		same = (stored.four_op == v.four_op) && (stored.fb == v.fb)
			&& (stored.ops[0] == v.ops[0]) && (stored.ops[1] == v.ops[1]);
		if (v.four_op) begin
			same = same && (stored.ops[2] == v.ops[2]) && (stored.ops[3] == v.ops[3]);
		end
		return same;
	endfunction

	// search in insertion order, append on a miss while there is room
	function automatic voice_result_t lookup_or_insert_voice(input vpd_entry_t v);
		voice_result_t r;
		r = '0;
		for (int unsigned i = 0; i < stored_voice_count; i++) begin
			if (voices_equal(voice_table[i], v)) begin
				r.voice_id  = i[ID_W-1:0];
				r.was_found = 1'b1;
				return r;
			end
		end
		if (stored_voice_count >= TABLE_DEPTH) begin
			r.table_full = 1'b1;
			return r;
		end
		voice_table[stored_voice_count] = v;
		r.voice_id = stored_voice_count[ID_W-1:0];
		stored_voice_count++;
		return r;
	endfunction

	function automatic vpd_entry_t make_voice(input logic four_op, input logic [FB_W-1:0] fb,
		input logic [OP_W-1:0] op0, input logic [OP_W-1:0] op1,
		input logic [OP_W-1:0] op2, input logic [OP_W-1:0] op3);
		vpd_entry_t v;
		v.four_op = four_op;
		v.fb      = fb;
		v.ops[0]  = op0;
		v.ops[1]  = op1;
		v.ops[2]  = op2;
		v.ops[3]  = op3;
		return v;
	endfunction

	// mostly repeats of stored voices, some one-bit variants, a few fresh voices
	function automatic vpd_entry_t pick_random_voice();
		vpd_entry_t  v;
		int unsigned roll;
		int unsigned sel;
		logic [1:0]  op_sel;
		roll = $urandom_range(0, 99);
		if (stored_voice_count == 0 || roll < 8) begin
			v.four_op = 1'($urandom_range(0, 1));
			v.fb      = FB_W'($urandom_range(0, 7));
			for (int k = 0; k < OPS_PER_ENTRY; k++) begin
				v.ops[k] = OP_W'($urandom());
			end
		end else begin
			v = voice_table[$urandom_range(0, stored_voice_count - 1)];
			if (!v.four_op) begin
				v.ops[2] = OP_W'($urandom());
				v.ops[3] = OP_W'($urandom());
			end
			if (roll < 20) begin
				sel = $urandom_range(0, 5);
				if (sel == 0) begin
					v.four_op = ~v.four_op;
				end else if (sel == 1) begin
					v.fb = v.fb ^ (FB_W'(1) << $urandom_range(0, FB_W - 1));
				end else begin
					op_sel        = 2'(sel - 2);
					v.ops[op_sel] = v.ops[op_sel] ^ (OP_W'(1) << $urandom_range(0, OP_W - 1));
				end
			end
		end
		return v;
	endfunction

	task automatic send_voice(input vpd_entry_t v);
		int unsigned gap;
		gap = $urandom_range(0, voice_gap_max);
		if (gap != 0) begin
			voice_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		voice_ch.valid                 <= 1'b1;
		voice_ch.four_op_mode          <= v.four_op;
		voice_ch.feedback              <= v.fb;
		voice_ch.operator_zero_fields  <= v.ops[0];
		voice_ch.operator_one_fields   <= v.ops[1];
		voice_ch.operator_two_fields   <= v.ops[2];
		voice_ch.operator_three_fields <= v.ops[3];
		do @(posedge clk); while (!voice_ch.ready);
		expected_results.push_back(lookup_or_insert_voice(v));
	endtask

	task automatic wait_results_drained();
		voice_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_matching();
		vpd_entry_t full_four;
		voice_gap_max    = 2;
		result_stall_max = 2;
		full_four = make_voice(1'b1, 3'd7, OP_ONES, OP_ONES, OP_ONES, OP_ONES);
		send_voice(make_voice(1'b0, 3'd0, '0, '0, '0, '0));
		send_voice(make_voice(1'b0, 3'd0, '0, '0, '0, '0));
		send_voice(full_four);
		send_voice(full_four);
		// unused operators differ, still a hit in two-op mode
		send_voice(make_voice(1'b0, 3'd0, '0, '0, OP_ONES, OP_ONES));
		send_voice(make_voice(1'b0, 3'd7, OP_ONES, OP_ONES, '0, '0));
		send_voice(make_voice(1'b0, 3'd7, OP_ONES, OP_ONES, OP_ONES, '0));
		send_voice(make_voice(1'b1, 3'd0, '0, '0, '0, '0));
		send_voice(make_voice(1'b1, 3'd0, '0, '0, '0, 29'd1));
		send_voice(make_voice(1'b1, 3'd0, '0, '0, 29'h1000_0000, '0));
		send_voice(make_voice(1'b0, 3'd1, '0, '0, '0, '0));
		send_voice(make_voice(1'b0, 3'd4, '0, '0, '0, '0));
		send_voice(make_voice(1'b0, 3'd0, 29'h1000_0000, '0, '0, '0));
		send_voice(make_voice(1'b0, 3'd0, '0, 29'h0AAA_AAAA, '0, '0));
		send_voice(make_voice(1'b1, 3'd7, OP_ONES, OP_ONES, 29'h1555_5555, OP_ONES));
		send_voice(make_voice(1'b1, 3'd0, '0, '0, '0, 29'd1));
		send_voice(make_voice(1'b0, 3'd0, '0, 29'h0AAA_AAAA, 29'h1234_5678, 29'h0765_4321));
		wait_results_drained();
	endtask

	task automatic test_random_mix(input int unsigned count);
		int unsigned gaps [4]   = '{8, 0, 8, 0};
		int unsigned stalls [4] = '{8, 0, 0, 8};
		for (int p = 0; p < 4; p++) begin
			voice_gap_max    = gaps[p];
			result_stall_max = stalls[p];
			repeat (count / 4) send_voice(pick_random_voice());
		end
		wait_results_drained();
	endtask

	task automatic test_receiver_hold();
		voice_gap_max       = 0;
		result_stall_max    = 0;
		result_hold_request = 300;
		repeat (10) send_voice(pick_random_voice());
		wait_results_drained();
	endtask

	task automatic test_table_full();
		voice_gap_max    = 3;
		result_stall_max = 3;
		while (stored_voice_count < TABLE_DEPTH) begin
			send_voice(make_voice(1'($urandom_range(0, 1)), FB_W'($urandom_range(0, 7)),
				OP_W'($urandom()), OP_W'($urandom()), OP_W'($urandom()),
				OP_W'($urandom())));
		end
		send_voice(make_voice(1'b1, 3'd5, 29'h0F0F_0F0F, 29'h10F0_F0F0, '0, OP_ONES));
		send_voice(voice_table[TABLE_DEPTH-1]);
		send_voice(voice_table[0]);
		send_voice(make_voice(1'b0, 3'd2, OP_ONES, '0, '0, '0));
		repeat (60) send_voice(pick_random_voice());
		wait_results_drained();
	endtask

	initial begin : result_sink
		voice_result_t exp_r;
		int unsigned   stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: voice_id %0d was_found %0b table_full %0b",
						result_ch.voice_id, result_ch.was_found, result_ch.table_full);
					mismatch_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (result_ch.voice_id !== exp_r.voice_id) begin
						$error("voice_id: expected %0d, got %0d", exp_r.voice_id,
							result_ch.voice_id);
						mismatch_count++;
					end
					if (result_ch.was_found !== exp_r.was_found) begin
						$error("was_found: expected %0b, got %0b", exp_r.was_found,
							result_ch.was_found);
						mismatch_count++;
					end
					if (result_ch.table_full !== exp_r.table_full) begin
						$error("table_full: expected %0b, got %0b", exp_r.table_full,
							result_ch.table_full);
						mismatch_count++;
					end
				end
				stall_left = $urandom_range(0, result_stall_max);
			end
			if (result_hold_request != 0) begin
				stall_left          = result_hold_request;
				result_hold_request = 0;
			end
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n                         <= 1'b0;
		voice_ch.valid                 <= 1'b0;
		voice_ch.four_op_mode          <= 1'b0;
		voice_ch.feedback              <= '0;
		voice_ch.operator_zero_fields  <= '0;
		voice_ch.operator_one_fields   <= '0;
		voice_ch.operator_two_fields   <= '0;
		voice_ch.operator_three_fields <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_matching();
		test_random_mix(800);
		test_receiver_hold();
		test_table_full();
		test_random_mix(120);
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
